FILE: src/wpfg_pkg.sv
`default_nettype none

package wpfg_pkg;

   // Counter width default and queue sizing.
   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Field widths.
   localparam int CHAN_BITS = 8;
   localparam int FRAC_BITS = 17;
   localparam int OUT_COUNT_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;

   // Fixed-point HSV constants.
   localparam int HSV_SHIFT = 12;
   localparam int HSV_HALF = 2048;
   localparam int HUE_RANGE = 180;
   localparam int SAT_SCALE = 255;
   localparam int SAT_RECIP_BITS = 20;
   localparam int HUE_RECIP_BITS = 17;

   // Register reset values.
   localparam logic [7:0] HUE_LOW_MAX_RESET = 8'd35;
   localparam logic [7:0] HUE_HIGH_MIN_RESET = 8'd170;
   localparam logic [7:0] SAT_MIN_RESET = 8'd130;
   localparam logic [7:0] VAL_MIN_RESET = 8'd200;
   localparam logic [FRAC_BITS-1:0] PASS_RATIO_RESET = '0;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HUE_LOW_MAX      = 3'd0,
      CSR_HUE_HIGH_MIN     = 3'd1,
      CSR_SAT_MIN          = 3'd2,
      CSR_VAL_MIN          = 3'd3,
      CSR_PASS_RATIO_Q16   = 3'd4
   } csr_index_type;

   // Classifier thresholds handed to the front end.
   typedef struct packed {
      logic [7:0] hue_low_max;
      logic [7:0] hue_high_min;
      logic [7:0] sat_min;
      logic [7:0] val_min;
   } cfg_type;

   // One classified pixel in the queue.
   typedef struct packed {
      logic warm;
      logic last;
   } queue_entry_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic            empty;
      queue_entry_type head;
   } queue_status_type;

   typedef logic [SAT_RECIP_BITS-1:0] sat_recip_table_type [256];
   typedef logic [HUE_RECIP_BITS-1:0] hue_recip_table_type [256];

   // Quotient of two non-negative constants by shift and subtract.
   function automatic longint const_quot(input longint num, input longint den);
      longint rem;
      longint quot;
      rem = num;
      quot = 0;
      for (int bit_pos = 31; bit_pos >= 0; bit_pos--) begin
         if (rem >= (den << bit_pos)) begin
            rem = rem - (den << bit_pos);
            quot = quot + (longint'(1) << bit_pos);
         end
      end
      return quot;
   endfunction

   // round((255 << 12) / v) for v = 1..255; zero for v = 0 gives zero saturation.
   function automatic sat_recip_table_type build_sat_recip();
      sat_recip_table_type tbl;
      tbl[0] = '0;
      for (int i = 1; i < 256; i++) begin
         tbl[i] = SAT_RECIP_BITS'(const_quot(2 * (SAT_SCALE << HSV_SHIFT) + i, 2 * i));
      end
      return tbl;
   endfunction

   // round((180 << 12) / (6 * d)) for d = 1..255; zero for d = 0 gives zero hue.
   function automatic hue_recip_table_type build_hue_recip();
      hue_recip_table_type tbl;
      tbl[0] = '0;
      for (int i = 1; i < 256; i++) begin
         tbl[i] = HUE_RECIP_BITS'(const_quot(2 * (HUE_RANGE << HSV_SHIFT) + 6 * i, 12 * i));
      end
      return tbl;
   endfunction

   localparam sat_recip_table_type SAT_RECIP = build_sat_recip();
   localparam hue_recip_table_type HUE_RECIP = build_hue_recip();

endpackage

`default_nettype wire

FILE: src/wpfg_front.sv
`default_nettype none

module wpfg_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_red,
   input  wire logic [7:0]               req_green,
   input  wire logic [7:0]               req_blue,
   input  wire logic                     req_last_pixel,
   input  wire wpfg_pkg::cfg_type        cfg,
   input  wire logic                     pop,
   output logic                          push,
   output wpfg_pkg::queue_entry_type     push_entry
);

   localparam int CB = wpfg_pkg::QUEUE_COUNT_BITS;

   logic          accept;
   logic [CB-1:0] credit_ff, credit_in;

   // Stage 1: max, min, difference and hue numerator.
   logic              s1_valid_ff;
   logic              s1_last_ff;
   logic [7:0]        s1_v_ff, s1_diff_ff;
   logic signed [11:0] s1_num_ff;
   logic [7:0]        v_in, mn_in, diff_in;
   logic [11:0]       num_in;

   // Stage 2: reciprocal lookups.
   logic              s2_valid_ff;
   logic              s2_last_ff;
   logic [7:0]        s2_v_ff, s2_diff_ff;
   logic signed [11:0] s2_num_ff;
   logic [wpfg_pkg::SAT_RECIP_BITS-1:0] s2_sat_recip_ff;
   logic [wpfg_pkg::HUE_RECIP_BITS-1:0] s2_hue_recip_ff;

   // Stage 3: products.
   logic              s3_valid_ff;
   logic              s3_last_ff;
   logic [7:0]        s3_v_ff;
   logic [27:0]       s3_sat_prod_ff;
   logic signed [29:0] s3_hue_prod_ff;
   logic [27:0]       sat_prod_in;
   logic signed [29:0] hue_prod_in;

   // Stage 4: rounding and threshold compare.
   logic              s4_valid_ff;
   logic              s4_last_ff;
   logic              s4_warm_ff;
   logic [28:0]       sat_sum;
   logic [16:0]       sat_val;
   logic signed [29:0] hue_sum;
   logic signed [17:0] hue_raw, hue_fix;
   logic [7:0]        hue_val;
   logic              warm_in;

   // Each credit is one free queue slot; the pipeline never stalls once an item is in.
   assign req_ready = (credit_ff != '0);
   assign accept = req_valid && req_ready;

   always_comb begin
      credit_in = credit_ff;
      if (accept && !pop) begin
         credit_in = credit_ff - CB'(1);
      end else if (!accept && pop) begin
         credit_in = credit_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= CB'(wpfg_pkg::QUEUE_DEPTH);
      end else begin
         credit_ff <= credit_in;
      end
   end

   // Channel extremes and the sector-dependent hue numerator.
   always_comb begin
      v_in = req_red;
      if (req_green > v_in) v_in = req_green;
      if (req_blue > v_in) v_in = req_blue;
      mn_in = req_red;
      if (req_green < mn_in) mn_in = req_green;
      if (req_blue < mn_in) mn_in = req_blue;
      diff_in = v_in - mn_in;
      priority if (v_in == req_red) begin
         num_in = {4'b0, req_green} - {4'b0, req_blue};
      end else if (v_in == req_green) begin
         num_in = {4'b0, req_blue} - {4'b0, req_red} + {3'b0, diff_in, 1'b0};
      end else begin
         num_in = {4'b0, req_red} - {4'b0, req_green} + {2'b0, diff_in, 2'b0};
      end
   end

   // Multiplications by the table reciprocals.
   assign sat_prod_in = s2_diff_ff * s2_sat_recip_ff;
   assign hue_prod_in = s2_num_ff * $signed({1'b0, s2_hue_recip_ff});

   // Round off twelve fraction bits, wrap negative hue into range and test the thresholds.
   always_comb begin
      sat_sum = 29'(s3_sat_prod_ff) + 29'(wpfg_pkg::HSV_HALF);
      sat_val = sat_sum[28:12];
      hue_sum = s3_hue_prod_ff + 30'(wpfg_pkg::HSV_HALF);
      hue_raw = $signed(hue_sum[29:12]);
      hue_fix = hue_raw[17] ? (hue_raw + 18'(wpfg_pkg::HUE_RANGE)) : hue_raw;
      hue_val = hue_fix[7:0];
      warm_in = ((hue_val <= cfg.hue_low_max) || (hue_val >= cfg.hue_high_min)) &&
                (sat_val >= {9'b0, cfg.sat_min}) && (s3_v_ff >= cfg.val_min);
   end

   // Valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      s1_last_ff      <= req_last_pixel;
      s1_v_ff         <= v_in;
      s1_diff_ff      <= diff_in;
      s1_num_ff       <= $signed(num_in);
      s2_last_ff      <= s1_last_ff;
      s2_v_ff         <= s1_v_ff;
      s2_diff_ff      <= s1_diff_ff;
      s2_num_ff       <= s1_num_ff;
      s2_sat_recip_ff <= wpfg_pkg::SAT_RECIP[s1_v_ff];
      s2_hue_recip_ff <= wpfg_pkg::HUE_RECIP[s1_diff_ff];
      s3_last_ff      <= s2_last_ff;
      s3_v_ff         <= s2_v_ff;
      s3_sat_prod_ff  <= sat_prod_in;
      s3_hue_prod_ff  <= hue_prod_in;
      s4_last_ff      <= s3_last_ff;
      s4_warm_ff      <= warm_in;
   end

   assign push = s4_valid_ff;
   assign push_entry.warm = s4_warm_ff;
   assign push_entry.last = s4_last_ff;

endmodule

`default_nettype wire

FILE: src/wpfg_queue.sv
`default_nettype none

module wpfg_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire wpfg_pkg::queue_entry_type push_entry,
   input  wire logic                      pop,
   output wpfg_pkg::queue_status_type     status
);

   localparam int PB = wpfg_pkg::QUEUE_PTR_BITS;
   localparam int CB = wpfg_pkg::QUEUE_COUNT_BITS;
   localparam logic [PB-1:0] LAST_SLOT = PB'(wpfg_pkg::QUEUE_DEPTH - 1);

   wpfg_pkg::queue_entry_type slot_ff [wpfg_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0] count_ff;

   // Slot storage; the front end's credits keep a push from landing on a full queue.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PB'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PB'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CB'(1);
         end else if (!push && pop) begin
            count_ff <= count_ff - CB'(1);
         end
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.head  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: src/wpfg_back.sv
`default_nettype none

module wpfg_back #(
   parameter int COUNT_BITS = wpfg_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire wpfg_pkg::queue_status_type            status,
   output logic                                       pop,
   input  wire logic [wpfg_pkg::FRAC_BITS-1:0]        pass_ratio_q16,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [wpfg_pkg::OUT_COUNT_BITS-1:0]        rsp_warm_count,
   output logic [wpfg_pkg::OUT_COUNT_BITS-1:0]        rsp_pixel_count,
   output logic                                       rsp_passed
);

   localparam int OB = wpfg_pkg::OUT_COUNT_BITS;
   localparam int FB = wpfg_pkg::FRAC_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] warm_ff, pixel_ff, warm_next, pixel_next;
   logic                  fin_valid_ff, fin_valid_in;
   logic [COUNT_BITS-1:0] fin_warm_ff, fin_pixel_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0]         rsp_warm_ff, rsp_pixel_ff;
   logic                  rsp_passed_ff;
   logic                  out_load, fin_free;
   logic [COUNT_BITS+FB-1:0] threshold;
   logic [COUNT_BITS+FB-1:0] scaled_warm;

   // Region-end counts move to the output register when it is free or being drained.
   assign out_load = fin_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign fin_free = !fin_valid_ff || out_load;
   assign pop = !status.empty && (!status.head.last || fin_free);

   // Saturating increments.
   assign warm_next  = warm_ff + COUNT_BITS'(status.head.warm && (warm_ff != COUNT_MAX));
   assign pixel_next = pixel_ff + COUNT_BITS'(pixel_ff != COUNT_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff  <= '0;
         pixel_ff <= '0;
      end else if (pop) begin
         if (status.head.last) begin
            warm_ff  <= '0;
            pixel_ff <= '0;
         end else begin
            warm_ff  <= warm_next;
            pixel_ff <= pixel_next;
         end
      end
   end

   // Final-count stage holds the closed region's totals.
   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (pop && status.head.last) begin
         fin_valid_in = 1'b1;
      end else if (out_load) begin
         fin_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && status.head.last) begin
         fin_warm_ff  <= warm_next;
         fin_pixel_ff <= pixel_next;
      end
   end

   // Pass test: warm * 65536 against the pass ratio times the total.
   assign threshold   = pass_ratio_q16 * fin_pixel_ff;
   assign scaled_warm = {1'b0, fin_warm_ff, 16'b0};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_warm_ff   <= OB'(fin_warm_ff);
         rsp_pixel_ff  <= OB'(fin_pixel_ff);
         rsp_passed_ff <= (scaled_warm >= threshold);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_warm_count  = rsp_warm_ff;
   assign rsp_pixel_count = rsp_pixel_ff;
   assign rsp_passed      = rsp_passed_ff;

endmodule

`default_nettype wire

FILE: src/warm_pixel_fraction_gate_unit.sv
// Path: a last pixel's result runs through the four classifier stages, the queue,
// the final-count register and the result register.
// Throughput: one pixel per cycle, set by the four-stage classifier pipeline and an
// eight-entry queue whose credits gate req_ready; one result per region.
// Reset: synchronous and active high; clears counts, queue and credits and restores
// the register reset values.
`default_nettype none

module warm_pixel_fraction_gate_unit #(
   parameter int COUNT_BITS = wpfg_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_ready,
   input  wire logic [7:0]                                 req_red,
   input  wire logic [7:0]                                 req_green,
   input  wire logic [7:0]                                 req_blue,
   input  wire logic                                       req_last_pixel,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_ready,
   output logic [wpfg_pkg::OUT_COUNT_BITS-1:0]             rsp_warm_count,
   output logic [wpfg_pkg::OUT_COUNT_BITS-1:0]             rsp_pixel_count,
   output logic                                            rsp_passed,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [wpfg_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  wire logic [wpfg_pkg::FRAC_BITS-1:0]             csr_data
);

   wpfg_pkg::cfg_type                  cfg_ff;
   logic [wpfg_pkg::FRAC_BITS-1:0]     pass_ratio_ff;
   logic                               push, pop;
   wpfg_pkg::queue_entry_type          push_entry;
   wpfg_pkg::queue_status_type         status;

   // Configuration registers; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low_max  <= wpfg_pkg::HUE_LOW_MAX_RESET;
         cfg_ff.hue_high_min <= wpfg_pkg::HUE_HIGH_MIN_RESET;
         cfg_ff.sat_min      <= wpfg_pkg::SAT_MIN_RESET;
         cfg_ff.val_min      <= wpfg_pkg::VAL_MIN_RESET;
         pass_ratio_ff       <= wpfg_pkg::PASS_RATIO_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (wpfg_pkg::csr_index_type'(csr_index))
            wpfg_pkg::CSR_HUE_LOW_MAX: begin
               cfg_ff.hue_low_max <= csr_data[7:0];
            end
            wpfg_pkg::CSR_HUE_HIGH_MIN: begin
               cfg_ff.hue_high_min <= csr_data[7:0];
            end
            wpfg_pkg::CSR_SAT_MIN: begin
               cfg_ff.sat_min <= csr_data[7:0];
            end
            wpfg_pkg::CSR_VAL_MIN: begin
               cfg_ff.val_min <= csr_data[7:0];
            end
            wpfg_pkg::CSR_PASS_RATIO_Q16: begin
               pass_ratio_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Pixel classifier.
   wpfg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .cfg            (cfg_ff),
      .pop            (pop),
      .push           (push),
      .push_entry     (push_entry)
   );

   // Decoupling queue.
   wpfg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (status)
   );

   // Counting and pass decision.
   wpfg_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (status),
      .pop              (pop),
      .pass_ratio_q16   (pass_ratio_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_warm_count   (rsp_warm_count),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_passed       (rsp_passed)
   );

endmodule

`default_nettype wire

FILE: src/wpfg_checker.sv
`default_nettype none

module wpfg_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [wpfg_pkg::OUT_COUNT_BITS-1:0] rsp_warm_count,
   input wire logic [wpfg_pkg::OUT_COUNT_BITS-1:0] rsp_pixel_count,
   input wire logic                                rsp_passed,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic [wpfg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [wpfg_pkg::FRAC_BITS-1:0]      csr_data
);

   logic [wpfg_pkg::FRAC_BITS-1:0] fraction_ff;
   logic                           frac_write;

   // Shadow of the pass threshold as written on the port.
   assign frac_write = csr_valid && csr_ready &&
                       (csr_index == wpfg_pkg::CSR_PASS_RATIO_Q16);

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_ff <= wpfg_pkg::PASS_RATIO_RESET;
      end else if (frac_write) begin
         fraction_ff <= csr_data;
      end
   end

   // A waiting result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_warm_count) &&
      $stable(rsp_pixel_count) && $stable(rsp_passed))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Reset restores every queue credit, so pixels are taken at once.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // A zero threshold always passes.
   a_zero_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (fraction_ff == '0) |-> rsp_passed)
      else $error("zero threshold failed");

endmodule

bind warm_pixel_fraction_gate_unit wpfg_checker u_checker (.*);

`default_nettype wire
